[rtl/psf_pkg.sv]
// Shared types, constants and helper functions of the progressive sample fill.
// Used by every module under rtl; depends on nothing else.
package psf_pkg;

	localparam int COORD_BITS      = 12;
	localparam int MAX_SAMPLE_BITS = 6;
	localparam int COLOR_BITS      = 32;
	localparam int SBITS_W         = 2;
	localparam int PASS_BITS       = 6;
	localparam int FRAME_BITS      = 13;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 13;
	localparam int OFS_BITS        = (1 << SBITS_W) - 1;
	localparam int BITS_W          = 3;
	localparam int DEPTH_W         = 3;
	localparam int CNT_W           = (MAX_SAMPLE_BITS > 0) ? MAX_SAMPLE_BITS : 1;
	localparam int IDX_W           = PASS_BITS;
	localparam int CMP_W           = (FRAME_BITS > COORD_BITS + 1) ? FRAME_BITS
	                                                                : COORD_BITS + 1;

	localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = FRAME_BITS'(640);
	localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = FRAME_BITS'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_SAMPLE_BITS = 3'd0,
		REG_Y_SAMPLE_BITS = 3'd1,
		REG_SAMPLE_PASS   = 3'd2,
		REG_FRAME_WIDTH   = 3'd3,
		REG_FRAME_HEIGHT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] width;
		logic [FRAME_BITS-1:0] height;
	} frame_cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] tile_x;
		logic [COORD_BITS-1:0] tile_y;
		logic [COLOR_BITS-1:0] color;
		logic [SBITS_W-1:0]    dx;
		logic [SBITS_W-1:0]    dy;
		logic [PASS_BITS-1:0]  pass;
		logic [DEPTH_W-1:0]    depth;
		logic [CNT_W-1:0]      last_i;
	} item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	typedef struct packed {
		logic [OFS_BITS-1:0] x;
		logic [OFS_BITS-1:0] y;
	} ofs_t;

	// Position of the highest set bit, zero for zero.
	function automatic logic [DEPTH_W-1:0] floor_log2(input logic [PASS_BITS-1:0] v);
		logic [DEPTH_W-1:0] d;
		d = '0;
		for (int k = 1; k < PASS_BITS; k++) begin
			if (v[k]) begin
				d = DEPTH_W'(k);
			end
		end
		return d;
	endfunction

	// Extra x bits first, then extra y bits, then x/y pairs; each bit enters at the LSB.
	function automatic ofs_t split_index(input logic [IDX_W-1:0] idx,
	                                     input logic [SBITS_W-1:0] dx,
	                                     input logic [SBITS_W-1:0] dy);
		logic [SBITS_W-1:0]  common;
		logic [SBITS_W-1:0]  ex;
		logic [SBITS_W-1:0]  ey;
		logic [IDX_W-1:0]    v;
		logic [OFS_BITS-1:0] x;
		logic [OFS_BITS-1:0] y;
		ofs_t                r;
		common = (dx < dy) ? dx : dy;
		ex     = dx - common;
		ey     = dy - common;
		v      = idx;
		x      = '0;
		y      = '0;
		for (int k = 0; k < OFS_BITS; k++) begin
			if (SBITS_W'(k) < ex) begin
				x = {x[OFS_BITS-2:0], v[0]};
				v = v >> 1;
			end
		end
		for (int k = 0; k < OFS_BITS; k++) begin
			if (SBITS_W'(k) < ey) begin
				y = {y[OFS_BITS-2:0], v[0]};
				v = v >> 1;
			end
		end
		for (int k = 0; k < OFS_BITS; k++) begin
			if (SBITS_W'(k) < common) begin
				x = {x[OFS_BITS-2:0], v[0]};
				y = {y[OFS_BITS-2:0], v[1]};
				v = v >> 2;
			end
		end
		r.x = x;
		r.y = y;
		return r;
	endfunction

endpackage

[rtl/psf_front.sv]
// Front end: configuration registers, sample intake and per-item classification,
// plus the two-entry item queue toward the back end. Depends on psf_pkg.
module psf_front import psf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic [COORD_BITS-1:0] tile_x,
	input  logic [COORD_BITS-1:0] tile_y,
	input  logic [COLOR_BITS-1:0] sample_color,
	output frame_cfg_t            frame,
	output item_t                 head,
	output logic                  head_vld,
	input  logic                  head_pop
);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = 1;

	logic [SBITS_W-1:0]    dx_q;
	logic [SBITS_W-1:0]    dy_q;
	logic [PASS_BITS-1:0]  pass_q;
	logic [FRAME_BITS-1:0] width_q;
	logic [FRAME_BITS-1:0] height_q;

	item_t                 mem_q [Q_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W:0]        cnt_q;

	logic [BITS_W-1:0]     sum_bits;
	logic [BITS_W-1:0]     bits;
	logic                  skip;
	logic [DEPTH_W-1:0]    depth;
	item_t                 item;
	logic                  accept;
	logic                  enq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q     <= '0;
			dy_q     <= '0;
			pass_q   <= '0;
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_X_SAMPLE_BITS: dx_q     <= cfg_wdata[SBITS_W-1:0];
				REG_Y_SAMPLE_BITS: dy_q     <= cfg_wdata[SBITS_W-1:0];
				REG_SAMPLE_PASS:   pass_q   <= cfg_wdata[PASS_BITS-1:0];
				REG_FRAME_WIDTH:   width_q  <= cfg_wdata[FRAME_BITS-1:0];
				REG_FRAME_HEIGHT:  height_q <= cfg_wdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign frame.width  = width_q;
	assign frame.height = height_q;

	always_comb begin
		sum_bits = BITS_W'({1'b0, dx_q}) + BITS_W'({1'b0, dy_q});
		bits     = (sum_bits > BITS_W'(MAX_SAMPLE_BITS)) ? BITS_W'(MAX_SAMPLE_BITS) : sum_bits;
		// A pass at or beyond the tile's sample count produces no writes at all.
		skip     = ({1'b0, pass_q} >= ((PASS_BITS + 1)'(1) << bits));
		depth    = floor_log2(pass_q);
		item.tile_x = tile_x;
		item.tile_y = tile_y;
		item.color  = sample_color;
		item.dx     = dx_q;
		item.dy     = dy_q;
		item.pass   = pass_q;
		item.depth  = depth;
		item.last_i = CNT_W'((32'd1 << (bits - BITS_W'(depth))) - 32'd1);
	end

	assign full     = (cnt_q == (PTR_W + 1)'(Q_DEPTH));
	assign accept   = push && !full;
	assign enq      = accept && !skip;
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(enq) - (PTR_W + 1)'(head_pop);
		end
	end

endmodule

[rtl/psf_back.sv]
// Back end: walks the sample indices of one item, maps them to pixels,
// drops off-frame writes and tags the final one. Depends on psf_pkg.
module psf_back import psf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frame_cfg_t frame,
	input  item_t      head,
	input  logic       head_vld,
	output logic       head_pop,
	output logic       out_push,
	output pixel_t     out_data,
	input  logic       out_full
);

	back_state_t           state_q;
	back_state_t           state_d;
	item_t                 item_q;
	item_t                 item_d;
	logic [CNT_W-1:0]      i_q;
	logic [CNT_W-1:0]      i_d;
	pixel_t                pend_q;
	pixel_t                pend_d;
	logic                  pend_vld_q;
	logic                  pend_vld_d;

	logic [IDX_W+CNT_W-1:0] idx_wide;
	logic [IDX_W-1:0]       idx;
	ofs_t                   ofs;
	logic [COORD_BITS:0]    px;
	logic [COORD_BITS:0]    py;
	logic                   cand_ok;
	pixel_t                 cand;

	always_comb begin
		idx_wide = {{IDX_W{1'b0}}, i_q} << item_q.depth;
		idx      = idx_wide[IDX_W-1:0] | item_q.pass;
		ofs      = split_index(idx, item_q.dx, item_q.dy);
		px       = {1'b0, item_q.tile_x} + {{(COORD_BITS + 1 - OFS_BITS){1'b0}}, ofs.x};
		py       = {1'b0, item_q.tile_y} + {{(COORD_BITS + 1 - OFS_BITS){1'b0}}, ofs.y};
		// Drop anything past the frame or past the coordinate range.
		cand_ok  = !px[COORD_BITS] && !py[COORD_BITS]
		        && (CMP_W'(px) < CMP_W'(frame.width))
		        && (CMP_W'(py) < CMP_W'(frame.height));
		cand.x     = px[COORD_BITS-1:0];
		cand.y     = py[COORD_BITS-1:0];
		cand.color = item_q.color;
		cand.last  = 1'b0;
	end

	always_comb begin
		state_d    = state_q;
		item_d     = item_q;
		i_d        = i_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		head_pop   = 1'b0;
		out_push   = 1'b0;
		out_data   = pend_q;
		case (state_q)
			BK_IDLE: begin
				if (head_vld) begin
					head_pop = 1'b1;
					item_d   = head;
					i_d      = '0;
					state_d  = BK_RUN;
				end
			end
			BK_RUN: begin
				// Hold back one write until the next one shows whether it was the final.
				if (!out_full) begin
					if (cand_ok) begin
						out_push   = pend_vld_q;
						out_data   = pend_q;
						pend_d     = cand;
						pend_vld_d = 1'b1;
					end
					i_d = i_q + CNT_W'(1);
					if (i_q == item_q.last_i) begin
						state_d = BK_FLUSH;
					end
				end
			end
			BK_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = BK_IDLE;
				end else if (!out_full) begin
					out_push      = 1'b1;
					out_data      = pend_q;
					out_data.last = 1'b1;
					pend_vld_d    = 1'b0;
					state_d       = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		i_q    <= i_d;
		pend_q <= pend_d;
	end

endmodule

[rtl/psf_outq.sv]
// Two-entry result queue that decouples the back end from the pixel sink.
// Depends on psf_pkg.
module psf_outq import psf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  pixel_t wr_data,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output pixel_t rd_data
);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = 1;

	pixel_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == (PTR_W + 1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(do_wr) - (PTR_W + 1)'(do_rd);
		end
	end

endmodule

[rtl/progressive_sample_fill.sv]
// Top level of the progressive sample fill: front end, back end and result queue.
// Depends on psf_pkg, psf_front, psf_back and psf_outq.
//
// Usage:
//   Samples enter through a queue-style port: drive tile_x, tile_y and sample_color
//   with push; a beat is taken on a clock edge where push is high and full is low.
//   Pixel writes leave through a second queue-style port: while empty is low the
//   oldest write sits on pixel_x, pixel_y, write_color and last; pop takes it.
//   last marks the final write of a sample; a sample whose writes all fall off the
//   frame, or whose pass is at or above the tile's sample count, gives no writes at all.
//   Configuration (tile size, pass, frame size) is written through cfg_we, cfg_idx
//   and cfg_wdata while the block is idle; unknown indices are ignored.
// Flow:
//   A sample with n = 2^(x_bits + y_bits - depth) candidates occupies the back end
//   through load, the walk (one candidate per cycle while the result queue is not
//   full) and a final flush before the next sample is loaded; the candidate walk in
//   the back end sets the rate. Two samples and two writes can be buffered.
// Reset and stalls:
//   arst_n clears all queues and restores the register defaults. When the sink
//   stops popping, the result queue fills, the back end holds and the front queue
//   raises full; nothing is dropped.
module progressive_sample_fill import psf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic [COORD_BITS-1:0] tile_x,
	input  logic [COORD_BITS-1:0] tile_y,
	input  logic [COLOR_BITS-1:0] sample_color,
	output logic                  empty,
	input  logic                  pop,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] write_color,
	output logic                  last
);

	frame_cfg_t frame;
	item_t      head;
	logic       head_vld;
	logic       head_pop;
	logic       out_push;
	pixel_t     out_data;
	logic       out_full;
	pixel_t     rd_data;

	psf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.tile_x       (tile_x),
		.tile_y       (tile_y),
		.sample_color (sample_color),
		.frame        (frame),
		.head         (head),
		.head_vld     (head_vld),
		.head_pop     (head_pop)
	);

	psf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.head     (head),
		.head_vld (head_vld),
		.head_pop (head_pop),
		.out_push (out_push),
		.out_data (out_data),
		.out_full (out_full)
	);

	psf_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (out_push),
		.wr_data (out_data),
		.full    (out_full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (rd_data)
	);

	assign pixel_x     = rd_data.x;
	assign pixel_y     = rd_data.y;
	assign write_color = rd_data.color;
	assign last        = rd_data.last;

endmodule
